/* rtl/jetp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jetp_pkg - Julia escape-time pixel package
// Shared widths, register codes, reset values, sequencer states and the
// configuration bundle for the escape-time pixel engine.
// ----------------------------------------------------------------------------
package jetp_pkg;

   localparam int COORD_W   = 32;
   localparam int STEP_W    = 31;
   localparam int ITER_W    = 16;
   localparam int PIX_W     = 11;
   localparam int FRAC_BITS = 28;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SQ_W      = PROD_W - 1 - FRAC_BITS;
   localparam int SUM_W     = SQ_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int PIX_CMP_W = 17;

   localparam int DEFAULT_IMAGE_WIDTH  = 2048;
   localparam int DEFAULT_IMAGE_HEIGHT = 2048;

   localparam logic [SUM_W-1:0] ESCAPE_LIMIT = SUM_W'(4) << FRAC_BITS;

   localparam logic signed [COORD_W-1:0] X_MIN_RESET  = -32'sd536870912;
   localparam logic signed [COORD_W-1:0] Y_MAX_RESET  = 32'sd536870912;
   localparam logic [STEP_W-1:0]         STEP_X_RESET = 31'd524288;
   localparam logic [STEP_W-1:0]         STEP_Y_RESET = 31'd524288;
   localparam logic signed [COORD_W-1:0] C_IMAG_RESET = 32'sd201326592;
   localparam logic [ITER_W-1:0]         MAX_ITER_RESET = 16'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_MIN    = 3'd0,
      CSR_Y_MAX    = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_C_IMAG   = 3'd4,
      CSR_MAX_ITER = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD_X,
      ST_COORD_Y,
      ST_SQ_U_FIRST,
      ST_SQ_U,
      ST_SQ_V,
      ST_UV,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x_min;
      logic signed [COORD_W-1:0] y_max;
      logic [STEP_W-1:0]         step_x;
      logic [STEP_W-1:0]         step_y;
      logic signed [COORD_W-1:0] c_imag;
      logic [ITER_W-1:0]         max_iter;
   } cfg_type;

endpackage
`default_nettype wire

/* rtl/jetp_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jetp_csr - configuration registers
// Holds the view window, pixel steps, Julia constant and iteration limit.
// ----------------------------------------------------------------------------
module jetp_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [jetp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [jetp_pkg::COORD_W-1:0]    csr_wdata,
   output jetp_pkg::cfg_type                    cfg
);

   jetp_pkg::cfg_type cfg_ff;
   jetp_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            jetp_pkg::CSR_X_MIN:    cfg_in.x_min    = $signed(csr_wdata);
            jetp_pkg::CSR_Y_MAX:    cfg_in.y_max    = $signed(csr_wdata);
            jetp_pkg::CSR_STEP_X:   cfg_in.step_x   = csr_wdata[jetp_pkg::STEP_W-1:0];
            jetp_pkg::CSR_STEP_Y:   cfg_in.step_y   = csr_wdata[jetp_pkg::STEP_W-1:0];
            jetp_pkg::CSR_C_IMAG:   cfg_in.c_imag   = $signed(csr_wdata);
            jetp_pkg::CSR_MAX_ITER: cfg_in.max_iter = csr_wdata[jetp_pkg::ITER_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min    <= jetp_pkg::X_MIN_RESET;
         cfg_ff.y_max    <= jetp_pkg::Y_MAX_RESET;
         cfg_ff.step_x   <= jetp_pkg::STEP_X_RESET;
         cfg_ff.step_y   <= jetp_pkg::STEP_Y_RESET;
         cfg_ff.c_imag   <= jetp_pkg::C_IMAG_RESET;
         cfg_ff.max_iter <= jetp_pkg::MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/jetp_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jetp_mul - shared signed multiplier
// One 32 by 32 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module jetp_mul (
   input  wire logic                                  clock,
   input  wire logic signed [jetp_pkg::COORD_W-1:0]   mul_a,
   input  wire logic signed [jetp_pkg::COORD_W-1:0]   mul_b,
   output logic signed [jetp_pkg::PROD_W-1:0]         prod
);

   logic signed [jetp_pkg::PROD_W-1:0] prod_ff;
   logic signed [jetp_pkg::PROD_W-1:0] prod_in;

   assign prod_in = jetp_pkg::PROD_W'(mul_a) * jetp_pkg::PROD_W'(mul_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

/* rtl/jetp_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// jetp_engine - escape-time sequencer and datapath
// Maps the pixel to its start point, then steps z = z^2 + c through the
// shared multiplier (u*u, v*v, u*v and step states) and issues the result.
// ----------------------------------------------------------------------------
module jetp_engine #(
   parameter int IMAGE_WIDTH  = jetp_pkg::DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = jetp_pkg::DEFAULT_IMAGE_HEIGHT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [jetp_pkg::PIX_W-1:0]            req_column,
   input  wire logic [jetp_pkg::PIX_W-1:0]            req_row,
   input  wire jetp_pkg::cfg_type                     cfg,
   output logic signed [jetp_pkg::COORD_W-1:0]        mul_a,
   output logic signed [jetp_pkg::COORD_W-1:0]        mul_b,
   input  wire logic signed [jetp_pkg::PROD_W-1:0]    prod,
   output logic                                       rsp_valid,
   output logic [jetp_pkg::ITER_W-1:0]                rsp_iterations,
   output logic                                       rsp_reached_limit
);

   localparam int PW = jetp_pkg::PIX_W;
   localparam int CW = jetp_pkg::COORD_W;
   localparam int XW = jetp_pkg::PIX_CMP_W;
   localparam int SW = jetp_pkg::SQ_W;
   localparam int FB = jetp_pkg::FRAC_BITS;
   localparam logic [XW-1:0] WIDTH_LIM  = XW'(IMAGE_WIDTH);
   localparam logic [XW-1:0] HEIGHT_LIM = XW'(IMAGE_HEIGHT);
   localparam logic [XW-1:0] WIDTH_LAST  = XW'(IMAGE_WIDTH - 1);
   localparam logic [XW-1:0] HEIGHT_LAST = XW'(IMAGE_HEIGHT - 1);

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [63:0] val);
      logic signed [CW-1:0] res;
      if ((&val[63:CW-1]) || !(|val[63:CW-1])) begin
         res = val[CW-1:0];
      end else if (val[63]) begin
         res = {1'b1, {(CW-1){1'b0}}};
      end else begin
         res = {1'b0, {(CW-1){1'b1}}};
      end
      return res;
   endfunction

   jetp_pkg::state_type state_ff, state_in;
   logic [PW-1:0]          col_ff, col_in;
   logic [PW-1:0]          row_ff, row_in;
   logic signed [CW-1:0]   u_ff, u_in;
   logic signed [CW-1:0]   v_ff, v_in;
   logic [SW-1:0]          u2_ff, u2_in;
   logic [SW-1:0]          v2_ff, v2_in;
   logic                   esc_ff, esc_in;
   logic [jetp_pkg::ITER_W-1:0] k_ff, k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [jetp_pkg::ITER_W-1:0] rsp_iter_ff, rsp_iter_in;
   logic                   rsp_limit_ff, rsp_limit_in;
   logic [PW-1:0]          col_clamped;
   logic [PW-1:0]          row_clamped;
   logic [SW-1:0]          sq_val;
   logic [jetp_pkg::SUM_W-1:0] sum_val;

   assign col_clamped = (XW'(req_column) >= WIDTH_LIM)  ? WIDTH_LAST[PW-1:0]  : req_column;
   assign row_clamped = (XW'(req_row)    >= HEIGHT_LIM) ? HEIGHT_LAST[PW-1:0] : req_row;
   assign sq_val      = prod[FB+SW-1:FB];
   assign sum_val     = {1'b0, u2_ff} + {1'b0, sq_val};

   assign busy              = (state_ff != jetp_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_iterations    = rsp_iter_ff;
   assign rsp_reached_limit = rsp_limit_ff;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      u2_in        = u2_ff;
      v2_in        = v2_ff;
      esc_in       = esc_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_iter_in  = rsp_iter_ff;
      rsp_limit_in = rsp_limit_ff;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         jetp_pkg::ST_IDLE: begin
            if (start) begin
               col_in   = col_clamped;
               row_in   = row_clamped;
               k_in     = jetp_pkg::ITER_W'(1);
               state_in = jetp_pkg::ST_COORD_X;
            end
         end
         jetp_pkg::ST_COORD_X: begin
            mul_a    = $signed(CW'(col_ff));
            mul_b    = $signed({1'b0, cfg.step_x});
            state_in = jetp_pkg::ST_COORD_Y;
         end
         jetp_pkg::ST_COORD_Y: begin
            mul_a    = $signed(CW'(row_ff));
            mul_b    = $signed({1'b0, cfg.step_y});
            u_in     = sat_coord(64'(cfg.x_min) + prod);
            state_in = jetp_pkg::ST_SQ_U_FIRST;
         end
         jetp_pkg::ST_SQ_U_FIRST: begin
            mul_a    = u_ff;
            mul_b    = u_ff;
            v_in     = sat_coord(64'(cfg.y_max) - prod);
            state_in = jetp_pkg::ST_SQ_V;
         end
         jetp_pkg::ST_SQ_U: begin
            mul_a    = u_ff;
            mul_b    = u_ff;
            state_in = jetp_pkg::ST_SQ_V;
         end
         jetp_pkg::ST_SQ_V: begin
            mul_a    = v_ff;
            mul_b    = v_ff;
            u2_in    = sq_val;
            state_in = jetp_pkg::ST_UV;
         end
         jetp_pkg::ST_UV: begin
            mul_a    = u_ff;
            mul_b    = v_ff;
            v2_in    = sq_val;
            esc_in   = (sum_val >= jetp_pkg::ESCAPE_LIMIT);
            state_in = jetp_pkg::ST_STEP;
         end
         jetp_pkg::ST_STEP: begin
            if ((k_ff < cfg.max_iter) && !esc_ff) begin
               u_in     = sat_coord($signed(64'(u2_ff)) - $signed(64'(v2_ff)));
               v_in     = sat_coord((prod >>> (FB - 1)) + 64'(cfg.c_imag));
               k_in     = k_ff + jetp_pkg::ITER_W'(1);
               state_in = jetp_pkg::ST_SQ_U;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_iter_in  = k_ff;
               rsp_limit_in = !esc_ff;
               state_in     = jetp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jetp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jetp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      u2_ff        <= u2_in;
      v2_ff        <= v2_in;
      esc_ff       <= esc_in;
      k_ff         <= k_in;
      rsp_iter_ff  <= rsp_iter_in;
      rsp_limit_ff <= rsp_limit_in;
   end

endmodule
`default_nettype wire

/* rtl/julia_escape_time_pixel_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_top - Julia set escape-time pixel
// One shared multiplier forms the u*u, v*v and u*v products of each
// iteration, followed by a step state. A new pixel is not taken while the
// last one is in flight; start is taken again in the strobe cycle. The
// receiver cannot stall. Reset restores the register defaults, returns the
// sequencer to idle and drops any pending result.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_top #(
   parameter int IMAGE_WIDTH  = jetp_pkg::DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = jetp_pkg::DEFAULT_IMAGE_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [jetp_pkg::PIX_W-1:0]      req_column,
   input  wire logic [jetp_pkg::PIX_W-1:0]      req_row,
   output logic                                 rsp_valid,
   output logic [jetp_pkg::ITER_W-1:0]          rsp_iterations,
   output logic                                 rsp_reached_limit,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [jetp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [jetp_pkg::COORD_W-1:0]    csr_wdata
);

   jetp_pkg::cfg_type                       cfg;
   logic signed [jetp_pkg::COORD_W-1:0]     mul_a;
   logic signed [jetp_pkg::COORD_W-1:0]     mul_b;
   logic signed [jetp_pkg::PROD_W-1:0]      prod;

   jetp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jetp_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   jetp_engine #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_column        (req_column),
      .req_row           (req_row),
      .cfg               (cfg),
      .mul_a             (mul_a),
      .mul_b             (mul_b),
      .prod              (prod),
      .rsp_valid         (rsp_valid),
      .rsp_iterations    (rsp_iterations),
      .rsp_reached_limit (rsp_reached_limit)
   );

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("sequencer finished without a result strobe");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule
`default_nettype wire

/* dv/pixel_escape_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_escape_checker - escape-count checker for the Julia pixel engine
// Watches the register, pixel and result channels. Keeps its own copy of the
// view registers, works out the escape count and limit flag of every pixel
// transfer in Q4.28 fixed point, and compares each result strobe with the
// oldest outstanding prediction. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module pixel_escape_checker
   import jetp_pkg::*;
#(
   parameter int IMAGE_WIDTH  = DEFAULT_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEFAULT_IMAGE_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [PIX_W-1:0]     req_column,
   input  logic [PIX_W-1:0]     req_row,
   input  logic                 rsp_valid,
   input  logic [ITER_W-1:0]    rsp_iterations,
   input  logic                 rsp_reached_limit,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata,
   input  logic                 drain_done,
   output int unsigned          outstanding,
   output int unsigned          errors
);

   typedef struct {
      logic [PIX_W-1:0]  column;
      logic [PIX_W-1:0]  row;
      logic [ITER_W-1:0] iterations;
      logic              reached_limit;
   } escape_result_type;

   cfg_type           shadow;
   escape_result_type pending_results[$];
   bit                leftovers_checked;

   function automatic longint clamp32(input longint value);
      if (value > longint'(32'sh7FFFFFFF))
         return longint'(32'sh7FFFFFFF);
      if (value < -longint'(64'h80000000))
         return -longint'(64'h80000000);
      return value;
   endfunction

   function automatic escape_result_type escape_count_of(input cfg_type view,
                                                         input logic [PIX_W-1:0] col_in,
                                                         input logic [PIX_W-1:0] row_in);
      longint            col;
      longint            row;
      longint            u;
      longint            v;
      longint            u_sq;
      longint            v_sq;
      longint            mag;
      longint            next_u;
      longint            next_v;
      int unsigned       count;
      int unsigned       cap;
      escape_result_type r;
      col = longint'(col_in);
      row = longint'(row_in);
      if (col > IMAGE_WIDTH - 1)
         col = IMAGE_WIDTH - 1;
      if (row > IMAGE_HEIGHT - 1)
         row = IMAGE_HEIGHT - 1;
      u = clamp32(longint'($signed(view.x_min)) + col * longint'(view.step_x));
      v = clamp32(longint'($signed(view.y_max)) - row * longint'(view.step_y));
      u_sq = (u * u) >>> FRAC_BITS;
      v_sq = (v * v) >>> FRAC_BITS;
      mag = u_sq + v_sq;
      if (mag > longint'(64'hFFFFFFFF))
         mag = longint'(64'hFFFFFFFF);
      count = 1;
      cap = int'(view.max_iter);
      while (count < cap && mag < longint'(ESCAPE_LIMIT)) begin
         next_v = clamp32(((u * v) >>> (FRAC_BITS - 1)) + longint'($signed(view.c_imag)));
         next_u = clamp32(u_sq - v_sq);
         u = next_u;
         v = next_v;
         u_sq = (u * u) >>> FRAC_BITS;
         v_sq = (v * v) >>> FRAC_BITS;
         mag = u_sq + v_sq;
         if (mag > longint'(64'hFFFFFFFF))
            mag = longint'(64'hFFFFFFFF);
         count++;
      end
      r.column = col_in;
      r.row = row_in;
      r.iterations = ITER_W'(count);
      r.reached_limit = (mag < longint'(ESCAPE_LIMIT));
      return r;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      escape_result_type due;
      if (reset) begin
         shadow = '{X_MIN_RESET, Y_MAX_RESET, STEP_X_RESET, STEP_Y_RESET,
                    C_IMAG_RESET, MAX_ITER_RESET};
         pending_results.delete();
         leftovers_checked = 1'b0;
         errors = 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_X_MIN:    shadow.x_min = csr_wdata;
               CSR_Y_MAX:    shadow.y_max = csr_wdata;
               CSR_STEP_X:   shadow.step_x = csr_wdata[STEP_W-1:0];
               CSR_STEP_Y:   shadow.step_y = csr_wdata[STEP_W-1:0];
               CSR_C_IMAG:   shadow.c_imag = csr_wdata;
               CSR_MAX_ITER: shadow.max_iter = csr_wdata[ITER_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               log_mismatch($sformatf("result %0d/%0b with no pixel outstanding",
                                      rsp_iterations, rsp_reached_limit));
            end else begin
               due = pending_results.pop_front();
               if (rsp_iterations !== due.iterations)
                  log_mismatch($sformatf("pixel (%0d,%0d) iterations %0d, want %0d",
                                         due.column, due.row, rsp_iterations,
                                         due.iterations));
               if (rsp_reached_limit !== due.reached_limit)
                  log_mismatch($sformatf("pixel (%0d,%0d) reached_limit %b, want %b",
                                         due.column, due.row, rsp_reached_limit,
                                         due.reached_limit));
            end
         end
         if (start && !busy)
            pending_results.push_back(escape_count_of(shadow, req_column, req_row));
         if (drain_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (pending_results.size() != 0)
               log_mismatch($sformatf("%0d pixel results never arrived",
                                      pending_results.size()));
         end
         outstanding <= pending_results.size();
      end
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - Julia escape-time pixel engine testbench
// Drives pixel requests and view register writes into the engine: a directed
// pass over the register extremes, iteration limits of zero, one and the
// maximum, coordinate and iteration saturation and unused register indexes,
// then about 700 random pixels over a series of random views with varying
// sender gaps. The checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
   import jetp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic [PIX_W-1:0]     PIX_LAST     = 11'd2047;
   localparam logic [PIX_W-1:0]     PIX_MID      = 11'd1024;
   localparam logic [STEP_W-1:0]    STEP_MAX     = 31'h7FFFFFFF;
   localparam logic [COORD_W-1:0]   COORD_MIN    = 32'h80000000;
   localparam logic [COORD_W-1:0]   COORD_MAX    = 32'h7FFFFFFF;
   localparam logic [COORD_W-1:0]   NEAR_EDGE    = 32'h16000000;
   localparam logic [ITER_W-1:0]    ITER_MAX     = 16'hFFFF;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [PIX_W-1:0]     req_column;
   logic [PIX_W-1:0]     req_row;
   logic                 rsp_valid;
   logic [ITER_W-1:0]    rsp_iterations;
   logic                 rsp_reached_limit;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;
   logic                 drain_done;
   int unsigned          outstanding;
   int unsigned          errors;
   int unsigned          idle_pct;

   julia_escape_time_pixel_top DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_iterations    (rsp_iterations),
      .rsp_reached_limit (rsp_reached_limit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   pixel_escape_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_iterations    (rsp_iterations),
      .rsp_reached_limit (rsp_reached_limit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .drain_done        (drain_done),
      .outstanding       (outstanding),
      .errors            (errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic cfg_type view(input logic [COORD_W-1:0] x_min,
                                    input logic [COORD_W-1:0] y_max,
                                    input logic [STEP_W-1:0]  step_x,
                                    input logic [STEP_W-1:0]  step_y,
                                    input logic [COORD_W-1:0] c_imag,
                                    input logic [ITER_W-1:0]  max_iter);
      cfg_type c;
      c.x_min = x_min;
      c.y_max = y_max;
      c.step_x = step_x;
      c.step_y = step_y;
      c.c_imag = c_imag;
      c.max_iter = max_iter;
      return c;
   endfunction

   function automatic cfg_type random_view();
      cfg_type c;
      if ($urandom_range(5) == 0) begin
         c.x_min = $urandom;
         c.y_max = $urandom;
         c.step_x = STEP_W'($urandom);
         c.step_y = STEP_W'($urandom);
         c.c_imag = $urandom;
      end else begin
         c.x_min = X_MIN_RESET + COORD_W'($urandom_range(0, 32'h20000000)) - 32'h10000000;
         c.y_max = Y_MAX_RESET + COORD_W'($urandom_range(0, 32'h20000000)) - 32'h10000000;
         c.step_x = STEP_W'($urandom_range(32'h10000, 32'h100000));
         c.step_y = STEP_W'($urandom_range(32'h10000, 32'h100000));
         c.c_imag = COORD_W'($urandom_range(0, 32'h30000000)) - 32'h18000000;
      end
      if ($urandom_range(9) == 0)
         c.max_iter = ITER_W'($urandom_range(0, 1));
      else
         c.max_iter = ITER_W'($urandom_range(2, 96));
      return c;
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      if ($urandom_range(7) == 0)
         return $urandom_range(1) ? PIX_LAST : '0;
      return PIX_W'($urandom_range(0, 2047));
   endfunction

   // hold off new pixels until every result is back
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic load_view(input cfg_type c, input bit poke_spare);
      settle();
      write_reg(CSR_X_MIN, c.x_min);
      write_reg(CSR_Y_MAX, c.y_max);
      write_reg(CSR_STEP_X, {1'($urandom), c.step_x});
      write_reg(CSR_STEP_Y, {1'($urandom), c.step_y});
      write_reg(CSR_C_IMAG, c.c_imag);
      write_reg(CSR_MAX_ITER, {16'($urandom), c.max_iter});
      if (poke_spare) begin
         write_reg(CSR_SPARE_LO, $urandom);
         write_reg(CSR_SPARE_HI, $urandom);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_column <= col;
      req_row <= row;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   initial begin
      int unsigned burst;
      reset = 1'b1;
      start = 1'b0;
      req_column = '0;
      req_row = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      drain_done = 1'b0;
      idle_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pixel('0, '0);
      send_pixel(PIX_LAST, PIX_LAST);
      send_pixel(PIX_MID, PIX_MID);
      send_pixel(PIX_MID, '0);
      send_pixel('0, PIX_MID);
      send_pixel(11'h555, 11'h2AA);
      send_pixel(11'h2AA, 11'h555);

      for (int lim = 0; lim < 3; lim++) begin
         load_view(view(X_MIN_RESET, Y_MAX_RESET, STEP_X_RESET, STEP_Y_RESET,
                        C_IMAG_RESET, ITER_W'(lim)), 1'b0);
         send_pixel(PIX_MID, PIX_MID);
         send_pixel('0, '0);
      end

      load_view(view(COORD_MIN, COORD_MAX, STEP_MAX, STEP_MAX, COORD_MIN, ITER_MAX), 1'b1);
      send_pixel(PIX_LAST, '0);
      send_pixel('0, PIX_LAST);
      send_pixel(PIX_LAST, PIX_LAST);
      send_pixel('0, '0);

      load_view(view('0, '0, '0, '0, COORD_MAX, ITER_MAX), 1'b0);
      send_pixel('0, '0);
      load_view(view('0, '0, '0, '0, '0, ITER_MAX), 1'b0);
      send_pixel(PIX_LAST, PIX_LAST);

      load_view(view(NEAR_EDGE, NEAR_EDGE, '0, '0, COORD_MAX, 16'd3), 1'b0);
      send_pixel('0, '0);
      load_view(view(NEAR_EDGE, -NEAR_EDGE, '0, '0, COORD_MIN, 16'd3), 1'b0);
      send_pixel(11'd5, 11'd9);

      for (int seg = 0; seg < 3; seg++) begin
         idle_pct = (seg == 0) ? 32 : (seg == 1) ? 87 : 0;
         for (int ph = 0; ph < 7; ph++) begin
            load_view(random_view(), $urandom_range(1));
            burst = $urandom_range(25, 42);
            repeat (burst) begin
               if ($urandom_range(49) == 0)
                  settle();
               send_pixel(random_pixel(), random_pixel());
            end
         end
      end

      settle();
      repeat (400) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
